// ===== src/zpd_pkg.sv =====
package zpd_pkg;

    localparam logic [7:0] PFX_DD = 8'hDD;
    localparam logic [7:0] PFX_FD = 8'hFD;
    localparam logic [7:0] PFX_ED = 8'hED;
    localparam logic [7:0] PFX_CB = 8'hCB;

    localparam logic [1:0] IDX_HL = 2'd0;
    localparam logic [1:0] IDX_IX = 2'd1;
    localparam logic [1:0] IDX_IY = 2'd2;

    localparam logic [1:0] KIND_MAIN = 2'd0;
    localparam logic [1:0] KIND_CB   = 2'd1;
    localparam logic [1:0] KIND_ED   = 2'd2;

    localparam logic [3:0] LEN_MAX = 4'd15;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_ED_OP  = 3'd1,
        PH_CB_DSP = 3'd2,
        PH_CB_OP  = 3'd3,
        PH_DISP   = 3'd4,
        PH_IMM    = 3'd5
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_word_t;

    typedef struct packed {
        logic [1:0]  index_mode;
        logic [1:0]  prefix_kind;
        logic [7:0]  opcode_byte;
        logic        has_displacement;
        logic [7:0]  displacement;
        logic [1:0]  immediate_count;
        logic [15:0] immediate;
        logic        unknown_code;
        logic [3:0]  byte_length;
    } rec_t;

    typedef struct packed {
        logic       need_disp;
        logic [1:0] imm_n;
        logic       unknown;
    } cls_t;

    function automatic cls_t classify(input logic [1:0] kind, input logic [7:0] op,
                                      input logic [1:0] im);
        cls_t       c;
        logic [1:0] x;
        logic [2:0] y;
        logic [2:0] z;
        logic [1:0] p;
        logic       q;
        logic       idx;
        x   = op[7:6];
        y   = op[5:3];
        z   = op[2:0];
        p   = op[5:4];
        q   = op[3];
        idx = (im != IDX_HL);
        c   = '0;
        if (kind == KIND_CB) begin
            c = '0;
        end else if (kind == KIND_ED) begin
            if (x == 2'd1) begin
                if (z == 3'd3) c.imm_n = 2'd2;
            end else if (!(x == 2'd2 && z <= 3'd3 && y >= 3'd4)) begin
                c.unknown = 1'b1;
            end
        end else begin
            case (x)
                2'd0: begin
                    case (z)
                        3'd0: if (y >= 3'd2) c.imm_n = 2'd1;
                        3'd1: if (!q) c.imm_n = 2'd2;
                        3'd2: if (y >= 3'd4) c.imm_n = 2'd2;
                        3'd4, 3'd5: if (y == 3'd6 && idx) c.need_disp = 1'b1;
                        3'd6: begin
                            c.imm_n = 2'd1;
                            if (y == 3'd6 && idx) c.need_disp = 1'b1;
                        end
                        default: c = '0;
                    endcase
                end
                2'd1: begin
                    if (!(y == 3'd6 && z == 3'd6) && (y == 3'd6 || z == 3'd6) && idx)
                        c.need_disp = 1'b1;
                end
                2'd2: begin
                    if (z == 3'd6 && idx) c.need_disp = 1'b1;
                end
                default: begin
                    case (z)
                        3'd2, 3'd4: c.imm_n = 2'd2;
                        3'd3: begin
                            if (y == 3'd0) c.imm_n = 2'd2;
                            else if (y inside {3'd2, 3'd3}) c.imm_n = 2'd1;
                        end
                        3'd5: if (q && p == 2'd0) c.imm_n = 2'd2;
                        3'd6: c.imm_n = 2'd1;
                        default: c = '0;
                    endcase
                end
            endcase
        end
        return c;
    endfunction

endpackage

// ===== src/zpd_in_reg.sv =====
module zpd_in_reg
    import zpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] code_byte,
    input  logic       advance,
    output byte_word_t word
);

    logic       valid_reg;
    logic [7:0] data_reg;

    assign in_ready   = !valid_reg || advance;
    assign word.valid = valid_reg;
    assign word.data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= code_byte;
        end
    end

endmodule

// ===== src/zpd_step.sv =====
module zpd_step
    import zpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  byte_word_t word,
    input  logic       advance,
    output logic       rec_valid,
    output rec_t       rec
);

    phase_t      phase_reg,  phase_next;
    logic [1:0]  im_reg,     im_next;
    logic [1:0]  kind_reg,   kind_next;
    logic [7:0]  op_reg,     op_next;
    logic [8:0]  disp_reg,   disp_next;
    logic [15:0] imm_reg,    imm_next;
    logic [1:0]  rem_reg,    rem_next;
    logic [3:0]  len_reg,    len_next;
    logic [7:0]  b;
    logic [3:0]  len_inc;
    logic [1:0]  pos;
    logic        emit;
    cls_t        cls;

    assign b       = word.data;
    assign len_inc = (len_reg < LEN_MAX) ? len_reg + 4'd1 : len_reg;

    always_comb
    begin
        im_next   = im_reg;
        kind_next = kind_reg;
        op_next   = op_reg;
        case (phase_reg)
            PH_ED_OP, PH_CB_OP: op_next = b;
            PH_PREFIX:
            begin
                if (b == PFX_DD) im_next = IDX_IX;
                else if (b == PFX_FD) im_next = IDX_IY;
                else if (b == PFX_ED)
                begin
                    kind_next = KIND_ED;
                    im_next   = IDX_HL;
                end
                else if (b == PFX_CB) kind_next = KIND_CB;
                else
                begin
                    kind_next = KIND_MAIN;
                    op_next   = b;
                end
            end
            default: op_next = op_reg;
        endcase
    end

    assign cls = classify(kind_next, op_next, im_next);
    assign pos = cls.imm_n - rem_reg;

    always_comb
    begin
        phase_next = phase_reg;
        disp_next  = disp_reg;
        imm_next   = imm_reg;
        rem_next   = rem_reg;
        len_next   = len_inc;
        emit       = 1'b0;
        case (phase_reg)
            PH_ED_OP, PH_CB_OP:
            begin
                rem_next = cls.imm_n;
                if (cls.need_disp) phase_next = PH_DISP;
                else if (cls.imm_n != 2'd0) phase_next = PH_IMM;
                else emit = 1'b1;
            end
            PH_CB_DSP:
            begin
                disp_next  = {1'b1, b};
                phase_next = PH_CB_OP;
            end
            PH_DISP:
            begin
                disp_next = {1'b1, b};
                if (rem_reg != 2'd0) phase_next = PH_IMM;
                else emit = 1'b1;
            end
            PH_IMM:
            begin
                if (pos == 2'd0) imm_next = imm_reg | {8'h00, b};
                else imm_next = imm_reg | {b, 8'h00};
                if (rem_reg != 2'd0) rem_next = rem_reg - 2'd1;
                if (rem_next == 2'd0) emit = 1'b1;
            end
            default:
            begin
                if (b == PFX_ED) phase_next = PH_ED_OP;
                else if (b == PFX_CB)
                    phase_next = (im_reg != IDX_HL) ? PH_CB_DSP : PH_CB_OP;
                else if (b != PFX_DD && b != PFX_FD)
                begin
                    rem_next = cls.imm_n;
                    if (cls.need_disp) phase_next = PH_DISP;
                    else if (cls.imm_n != 2'd0) phase_next = PH_IMM;
                    else emit = 1'b1;
                end
            end
        endcase

        rec.index_mode       = im_next;
        rec.prefix_kind      = kind_next;
        rec.opcode_byte      = op_next;
        rec.has_displacement = disp_next[8];
        rec.displacement     = disp_next[7:0];
        rec.immediate_count  = cls.imm_n;
        rec.immediate        = imm_next;
        rec.unknown_code     = cls.unknown;
        rec.byte_length      = len_inc;
    end

    assign rec_valid = advance && word.valid && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX;
            im_reg    <= IDX_HL;
            kind_reg  <= KIND_MAIN;
            op_reg    <= '0;
            disp_reg  <= '0;
            imm_reg   <= '0;
            rem_reg   <= '0;
            len_reg   <= '0;
        end
        else if (advance && word.valid)
        begin
            if (emit)
            begin
                phase_reg <= PH_PREFIX;
                im_reg    <= IDX_HL;
                kind_reg  <= KIND_MAIN;
                op_reg    <= '0;
                disp_reg  <= '0;
                imm_reg   <= '0;
                rem_reg   <= '0;
                len_reg   <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                im_reg    <= im_next;
                kind_reg  <= kind_next;
                op_reg    <= op_next;
                disp_reg  <= disp_next;
                imm_reg   <= imm_next;
                rem_reg   <= rem_next;
                len_reg   <= len_next;
            end
        end
    end

    a_imm_pending: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IMM |-> rem_reg != 2'd0)
        else $error("immediate phase with nothing left to take");

    a_disp_indexed: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec.has_displacement |-> rec.index_mode != IDX_HL)
        else $error("displacement on an unindexed instruction");

    a_ed_hl: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec.prefix_kind == KIND_ED |-> rec.index_mode == IDX_HL)
        else $error("ED instruction left indexed");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid |=> phase_reg == PH_PREFIX && len_reg == 4'd0)
        else $error("state not cleared after record");

endmodule

// ===== src/zpd_out_reg.sv =====
module zpd_out_reg
    import zpd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic rec_valid,
    input  rec_t rec,
    output logic advance,
    output logic out_valid,
    input  logic out_ready,
    output rec_t out_rec
);

    logic valid_reg;
    rec_t rec_reg;

    assign advance   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= rec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && rec_valid)
        begin
            rec_reg <= rec;
        end
    end

endmodule

// ===== src/z80_instruction_predecoder_core.sv =====
// Z80 instruction predecoder. Takes one code byte a cycle while the result register
// drains, and returns one decoded word on the byte that completes an instruction
// (prefixes, opcode, displacement, immediates). A byte passes an input register, the
// phase machine and a result register, and the word is registered in the result
// register; a full result register that waits on out_ready stalls the input.
module z80_instruction_predecoder_core
    import zpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  code_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  index_mode,
    output logic [1:0]  prefix_kind,
    output logic [7:0]  opcode_byte,
    output logic        has_displacement,
    output logic [7:0]  displacement,
    output logic [1:0]  immediate_count,
    output logic [15:0] immediate,
    output logic        unknown_code,
    output logic [3:0]  byte_length
);

    byte_word_t word;
    logic       advance;
    logic       rec_valid;
    rec_t       rec;
    rec_t       out_rec;

    zpd_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .code_byte (code_byte),
        .advance   (advance),
        .word      (word)
    );

    zpd_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .word      (word),
        .advance   (advance),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    zpd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec       (rec),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rec   (out_rec)
    );

    assign index_mode       = out_rec.index_mode;
    assign prefix_kind      = out_rec.prefix_kind;
    assign opcode_byte      = out_rec.opcode_byte;
    assign has_displacement = out_rec.has_displacement;
    assign displacement     = out_rec.displacement;
    assign immediate_count  = out_rec.immediate_count;
    assign immediate        = out_rec.immediate;
    assign unknown_code     = out_rec.unknown_code;
    assign byte_length      = out_rec.byte_length;

endmodule
